// ===== hw/rtl/pfci_pkg.sv =====
// ----------------------------------------------------------------------------
// pfci_pkg: shared types and constants of the parallel flash command interface
// Beat payload structs, controller/datapath interface structs, command
// decode constants and configuration register map.
// ----------------------------------------------------------------------------
package pfci_pkg;

  // bus command codes of an input beat
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // command decode: low address bits and data bytes
  localparam int          CMD_ADDR_W    = 11;
  localparam logic [10:0] ADDR_UNLOCK_A = 11'h555;
  localparam logic [10:0] ADDR_UNLOCK_B = 11'h2AA;
  localparam logic [7:0]  DATA_UNLOCK_A = 8'hAA;
  localparam logic [7:0]  DATA_UNLOCK_B = 8'h55;
  localparam logic [7:0]  DATA_PROGRAM  = 8'hA0;
  localparam logic [7:0]  DATA_ERASE    = 8'h80;
  localparam logic [7:0]  DATA_CHIP_ERS = 8'h10;
  localparam logic [7:0]  DATA_RESET    = 8'hF0;

  // status byte bits
  localparam logic [7:0]  DQ7_MASK = 8'h80;
  localparam logic [7:0]  DQ6_MASK = 8'h40;
  localparam logic [7:0]  DQ5_MASK = 8'h20;
  localparam logic [7:0]  ERASED   = 8'hFF;

  // busy counter
  localparam int          CNT_W     = 24;
  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

  // configuration port
  localparam int          CFG_ADDR_W = 3;
  localparam int          CFG_DATA_W = 32;
  localparam logic        REG_PROGRAM_TIME = 1'b0;
  localparam logic        REG_ERASE_TIME   = 1'b1;
  localparam logic [15:0] PROGRAM_TIME_RST = 16'd8;
  localparam logic [23:0] ERASE_TIME_RST   = 24'h010000;

  // input beat
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_t;

  // result beat
  typedef struct packed {
    logic [7:0] read_data;
    logic       busy_res;
  } out_t;

  // configuration register values
  typedef struct packed {
    logic [15:0] program_time;
    logic [23:0] erase_time;
  } cfg_t;

  // source of the result byte
  typedef enum logic [1:0] {
    OSEL_ZERO,
    OSEL_STATUS,
    OSEL_ARRAY
  } out_sel_t;

  // controller -> datapath commands
  typedef struct packed {
    logic     clr_step;    // clearing pass: write erased byte at pointer
    logic     erase_step;  // erase walk: write erased byte at pointer if not done
    logic     ptr_clr;
    logic     arr_rd;      // read array at beat address
    logic     tgt_rd;      // read array at program target
    logic     tgt_wb;      // write back old AND target data
    logic     tgt_load;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     status_rd;   // flip toggle bit
    logic     dq7_en;
    logic     dq5;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_busy;
  } ctl_t;

  // datapath -> controller status
  typedef struct packed {
    logic ptr_last;       // pointer is full or one step from full
    logic prog_reached;   // incremented count meets program time
    logic erase_reached;  // incremented count meets erase time
    logic prog_fail;      // program would set a cleared bit
  } sts_t;

endpackage

// ===== hw/rtl/pfci_cfg.sv =====
// ----------------------------------------------------------------------------
// pfci_cfg: configuration register file
// APB-style slave holding program and erase busy times, with read back.
// ----------------------------------------------------------------------------
module pfci_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pfci_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [pfci_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [pfci_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready,
  output pfci_pkg::cfg_t                     cfg
);
  import pfci_pkg::*;

  logic [15:0] program_time_r;
  logic [23:0] erase_time_r;
  logic        reg_idx;
  logic        wr_en;

  assign reg_idx    = cfg_paddr[2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      program_time_r <= PROGRAM_TIME_RST;
      erase_time_r   <= ERASE_TIME_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PROGRAM_TIME: program_time_r <= cfg_pwdata[15:0];
        REG_ERASE_TIME:   erase_time_r   <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_PROGRAM_TIME: cfg_prdata = CFG_DATA_W'(program_time_r);
      REG_ERASE_TIME:   cfg_prdata = CFG_DATA_W'(erase_time_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg.program_time = program_time_r;
  assign cfg.erase_time   = erase_time_r;

endmodule

// ===== hw/rtl/pfci_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfci_ctrl: controller
// Holds the flash command sequencer and the beat flow state machine, and
// issues commands to the datapath.
// ----------------------------------------------------------------------------
module pfci_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pfci_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  input  pfci_pkg::sts_t sts,
  output pfci_pkg::ctl_t ctl
);
  import pfci_pkg::*;

  // command sequence stage
  typedef enum logic [9:0] {
    ST_READ  = 10'b0000000001,
    ST_U1    = 10'b0000000010,
    ST_U2    = 10'b0000000100,
    ST_ARMED = 10'b0000001000,
    ST_E1    = 10'b0000010000,
    ST_E2    = 10'b0000100000,
    ST_E3    = 10'b0001000000,
    ST_PROG  = 10'b0010000000,
    ST_ERASE = 10'b0100000000,
    ST_FAIL  = 10'b1000000000
  } stage_t;

  // beat flow
  typedef enum logic [3:0] {
    F_CLEAR   = 4'b0001,
    F_IDLE    = 4'b0010,
    F_ARRAY_RD = 4'b0100,
    F_PROG_WB = 4'b1000
  } flow_t;

  stage_t      stage_r, stage_nxt;
  flow_t       flow_r, flow_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_fire;
  logic        busy;
  logic [10:0] ca;
  logic [7:0]  wd;
  logic        hit_a, hit_b;

  function automatic logic stage_busy(input stage_t s);
    return (s == ST_PROG) || (s == ST_ERASE) || (s == ST_FAIL);
  endfunction

  assign busy      = stage_busy(stage_r);
  assign ca        = in_data.address[CMD_ADDR_W-1:0];
  assign wd        = in_data.write_data;
  assign hit_a     = (ca == ADDR_UNLOCK_A);
  assign hit_b     = (ca == ADDR_UNLOCK_B);
  assign in_ready  = (flow_r == F_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // next state and datapath commands
  always_comb begin
    stage_nxt     = stage_r;
    flow_nxt      = flow_r;
    ctl           = '0;
    ctl.out_sel   = OSEL_ZERO;
    out_valid_nxt = out_valid_r && !out_ready;

    case (flow_r)
      F_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.ptr_last) begin
          flow_nxt = F_IDLE;
        end
      end

      F_IDLE: begin
        if (in_fire) begin
          case (in_data.command)
            CMD_READ: begin
              if (busy) begin
                // data polling status
                ctl.status_rd = 1'b1;
                ctl.dq7_en    = (stage_r != ST_ERASE);
                ctl.dq5       = (stage_r == ST_FAIL);
                ctl.out_load  = 1'b1;
                ctl.out_sel   = OSEL_STATUS;
                ctl.out_busy  = 1'b1;
              end else begin
                ctl.arr_rd = 1'b1;
                flow_nxt   = F_ARRAY_RD;
              end
            end

            CMD_WRITE: begin
              if (busy) begin
                if (stage_r == ST_FAIL && wd == DATA_RESET) begin
                  stage_nxt = ST_READ;
                end
              end else if (stage_r == ST_ARMED) begin
                ctl.tgt_load = 1'b1;
                ctl.cnt_clr  = 1'b1;
                stage_nxt    = ST_PROG;
              end else if (wd == DATA_RESET) begin
                stage_nxt = ST_READ;
              end else begin
                case (stage_r)
                  ST_READ: stage_nxt = (hit_a && wd == DATA_UNLOCK_A) ? ST_U1 : ST_READ;
                  ST_U1:   stage_nxt = (hit_b && wd == DATA_UNLOCK_B) ? ST_U2 : ST_READ;
                  ST_U2: begin
                    if (hit_a && wd == DATA_PROGRAM) begin
                      stage_nxt = ST_ARMED;
                    end else if (hit_a && wd == DATA_ERASE) begin
                      stage_nxt = ST_E1;
                    end else begin
                      stage_nxt = ST_READ;
                    end
                  end
                  ST_E1:   stage_nxt = (hit_a && wd == DATA_UNLOCK_A) ? ST_E2 : ST_READ;
                  ST_E2:   stage_nxt = (hit_b && wd == DATA_UNLOCK_B) ? ST_E3 : ST_READ;
                  ST_E3: begin
                    if (hit_a && wd == DATA_CHIP_ERS) begin
                      stage_nxt   = ST_ERASE;
                      ctl.cnt_clr = 1'b1;
                      ctl.ptr_clr = 1'b1;
                    end else begin
                      stage_nxt = ST_READ;
                    end
                  end
                  default: stage_nxt = ST_READ;
                endcase
              end
              ctl.out_load = 1'b1;
              ctl.out_busy = stage_busy(stage_nxt);
            end

            CMD_TICK: begin
              case (stage_r)
                ST_PROG: begin
                  ctl.cnt_inc = 1'b1;
                  if (sts.prog_reached) begin
                    // read old cell, write back next cycle
                    ctl.tgt_rd = 1'b1;
                    flow_nxt   = F_PROG_WB;
                  end else begin
                    ctl.out_load = 1'b1;
                    ctl.out_busy = 1'b1;
                  end
                end
                ST_ERASE: begin
                  ctl.cnt_inc    = 1'b1;
                  ctl.erase_step = 1'b1;
                  ctl.out_load   = 1'b1;
                  if (sts.ptr_last && sts.erase_reached) begin
                    stage_nxt    = ST_READ;
                    ctl.out_busy = 1'b0;
                  end else begin
                    ctl.out_busy = 1'b1;
                  end
                end
                default: begin
                  ctl.out_load = 1'b1;
                  ctl.out_busy = busy;
                end
              endcase
            end

            default: begin
              ctl.out_load = 1'b1;
              ctl.out_busy = busy;
            end
          endcase
        end
      end

      F_ARRAY_RD: begin
        ctl.out_load = 1'b1;
        ctl.out_sel  = OSEL_ARRAY;
        ctl.out_busy = 1'b0;
        flow_nxt     = F_IDLE;
      end

      F_PROG_WB: begin
        ctl.tgt_wb   = 1'b1;
        stage_nxt    = sts.prog_fail ? ST_FAIL : ST_READ;
        ctl.out_load = 1'b1;
        ctl.out_busy = sts.prog_fail;
        flow_nxt     = F_IDLE;
      end

      default: flow_nxt = F_IDLE;
    endcase

    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= ST_READ;
      flow_r      <= F_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      stage_r     <= stage_nxt;
      flow_r      <= flow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/pfci_dp.sv =====
// ----------------------------------------------------------------------------
// pfci_dp: datapath
// Cell array memory, busy counter, erase pointer, program target, toggle bit
// and the result register.
// ----------------------------------------------------------------------------
module pfci_dp #(
  parameter int ADDR_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pfci_pkg::ctl_t ctl,
  input  pfci_pkg::cfg_t cfg,
  input  pfci_pkg::in_t  in_data,
  output pfci_pkg::sts_t sts,
  output pfci_pkg::out_t out_data
);
  import pfci_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;
  localparam int EXT_W = (ADDR_BITS > 16) ? ADDR_BITS : 16;

  logic [7:0]           mem [DEPTH];
  logic [7:0]           rd_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [ADDR_BITS:0]   ptr_r;
  logic [ADDR_BITS-1:0] tgt_addr_r;
  logic [7:0]           tgt_data_r;
  logic                 toggle_r;
  out_t                 out_r;

  logic [EXT_W-1:0]     addr_ext;
  logic [ADDR_BITS-1:0] in_idx;
  logic [CNT_W-1:0]     cnt_inc_v;
  logic [15:0]          ptime_eff;
  logic [CNT_W-1:0]     etime_eff;
  logic                 ptr_full;
  logic                 we;
  logic [ADDR_BITS-1:0] waddr;
  logic [7:0]           wdata;
  logic                 re;
  logic [ADDR_BITS-1:0] raddr;
  logic [7:0]           status;
  logic [7:0]           rd_byte;

  // array index of the beat address
  assign addr_ext = EXT_W'(in_data.address);
  assign in_idx   = addr_ext[ADDR_BITS-1:0];

  // counter compare; zero time acts as one
  assign cnt_inc_v = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 24'd1;
  assign ptime_eff = (cfg.program_time == 16'd0) ? 16'd1 : cfg.program_time;
  assign etime_eff = (cfg.erase_time == 24'd0) ? 24'd1 : cfg.erase_time;

  assign ptr_full          = ptr_r[ADDR_BITS];
  assign sts.ptr_last      = ptr_full || (&ptr_r[ADDR_BITS-1:0]);
  assign sts.prog_reached  = (cnt_inc_v >= CNT_W'(ptime_eff));
  assign sts.erase_reached = (cnt_inc_v >= etime_eff);
  assign sts.prog_fail     = |(tgt_data_r & ~rd_r);

  // memory port selection
  assign we    = ctl.clr_step || ctl.tgt_wb || (ctl.erase_step && !ptr_full);
  assign waddr = ctl.tgt_wb ? tgt_addr_r : ptr_r[ADDR_BITS-1:0];
  assign wdata = ctl.tgt_wb ? (rd_r & tgt_data_r) : ERASED;
  assign re    = ctl.arr_rd || ctl.tgt_rd;
  assign raddr = ctl.tgt_rd ? tgt_addr_r : in_idx;

  // cell array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  // operation state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ptr_r      <= '0;
      tgt_addr_r <= '0;
      tgt_data_r <= '0;
      toggle_r   <= 1'b0;
    end else begin
      if (ctl.cnt_clr) begin
        cnt_r <= '0;
      end else if (ctl.cnt_inc) begin
        cnt_r <= cnt_inc_v;
      end
      if (ctl.ptr_clr) begin
        ptr_r <= '0;
      end else if (ctl.clr_step || (ctl.erase_step && !ptr_full)) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (ctl.tgt_load) begin
        tgt_addr_r <= in_idx;
        tgt_data_r <= in_data.write_data;
      end
      if (ctl.status_rd) begin
        toggle_r <= ~toggle_r;
      end
    end
  end

  // data polling status byte
  always_comb begin
    status = '0;
    if (ctl.dq7_en && !tgt_data_r[7]) begin
      status = status | DQ7_MASK;
    end
    if (toggle_r) begin
      status = status | DQ6_MASK;
    end
    if (ctl.dq5) begin
      status = status | DQ5_MASK;
    end
  end

  // result byte selection
  always_comb begin
    case (ctl.out_sel)
      OSEL_STATUS: rd_byte = status;
      OSEL_ARRAY:  rd_byte = rd_r;
      default:     rd_byte = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_r.read_data <= rd_byte;
      out_r.busy_res  <= ctl.out_busy;
    end
  end

  assign out_data = out_r;

endmodule

// ===== hw/rtl/parallel_flash_command_interface_core.sv =====
// ----------------------------------------------------------------------------
// parallel_flash_command_interface_core: byte-wide flash device model
// JEDEC-style command set with data polling, driven by bus read, bus write
// and time tick beats.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that writes 0xFF to every cell,
// during which in_ready stays low; configuration writes are taken
// throughout. Afterwards one beat is handled at a time: a bus write, a
// status read while busy, a tick and an unused command finish in the cycle
// they are taken; an array read and the tick that completes a byte program
// pass through a second flow state, F_ARRAY_RD or F_PROG_WB. This is set by
// the registered read of the cell array: array data is available the cycle
// after the address, and a program completion reads the old cell before
// writing it. A result beat sits in an output register; the next input beat
// is taken in the cycle that result is taken.
module parallel_flash_command_interface_core #(
  parameter int ADDR_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pfci_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pfci_pkg::out_t                     out_data,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pfci_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [pfci_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [pfci_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import pfci_pkg::*;

  cfg_t cfg;
  ctl_t ctl;
  sts_t sts;

  // configuration registers
  pfci_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // controller
  pfci_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // datapath
  pfci_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .cfg      (cfg),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== hw/rtl/pfci_checker.sv =====
// ----------------------------------------------------------------------------
// pfci_checker: port-level assertions
// Checks beat flow and result timing seen on the top level ports.
// ----------------------------------------------------------------------------
module pfci_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input pfci_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input pfci_pkg::out_t out_data,
  input logic           cfg_pready
);
  import pfci_pkg::*;

  // input side never takes a beat while a result is blocked
  a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("input taken while result register is blocked");

  // a bus write answers in the next cycle with a zero byte
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == CMD_WRITE)
      |=> (out_valid && out_data.read_data == 8'd0))
    else $error("bus write result missing or nonzero");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port not ready");

endmodule

bind parallel_flash_command_interface_core pfci_checker u_pfci_checker (.*);
